[rtl/core/nmsdp_pkg.sv]
// Shared types and constants for the N:M sparse masked dot product block.
// No dependencies; every other file in rtl/core but nmsdp_ram uses this package.
`default_nettype none

package nmsdp_pkg;

  localparam int LANE_W    = 8;
  localparam int VALS_W    = 64;
  localparam int IDX_W     = 8;
  localparam int ACC_W     = 32;
  localparam int PROD_W    = 16;
  localparam int SUM_W     = 20;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_WEIGHT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEPT_PER_GROUP = 4'd1;

  localparam logic [CFG_W-1:0] GS_RESET   = 4'd4;
  localparam logic [CFG_W-1:0] KEPT_RESET = 4'd2;
  localparam logic [CFG_W-1:0] GS_MIN     = 4'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  // result queue: also bounds how many row results may be in flight
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CNT_W = 4;
  localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = 4'd8;

  typedef struct packed {
    logic                    valid;
    logic                    row_first;
    logic                    row_last;
    logic signed [ACC_W-1:0] bias;
  } ctrl_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] y;
    logic                    status;
    logic                    saturated;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/core/nmsdp_req_if.sv]
// Request channel: load and weight beats with valid/ready.
// Depends on nmsdp_pkg for field widths.
`default_nettype none

interface nmsdp_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [nmsdp_pkg::IDX_W-1:0]         group_index;
  logic [nmsdp_pkg::VALS_W-1:0]        lane_values;
  logic [nmsdp_pkg::LANE_W-1:0]        mask;
  logic signed [nmsdp_pkg::ACC_W-1:0]  bias;
  logic                                row_first;
  logic                                row_last;

  modport source (output valid, req_type, group_index, lane_values, mask, bias,
                  row_first, row_last, input ready);
  modport sink   (input valid, req_type, group_index, lane_values, mask, bias,
                  row_first, row_last, output ready);
endinterface

`default_nettype wire

[rtl/core/nmsdp_rsp_if.sv]
// Result channel: one beat per finished row, valid/ready.
// Depends on nmsdp_pkg for field widths.
`default_nettype none

interface nmsdp_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [nmsdp_pkg::ACC_W-1:0]  y;
  logic                                status;
  logic                                saturated;

  modport source (output valid, y, status, saturated, input ready);
  modport sink   (input valid, y, status, saturated, output ready);
endinterface

`default_nettype wire

[rtl/core/nmsdp_cfg_if.sv]
// Configuration write channel: register index and data with valid/ready.
// Depends on nmsdp_pkg for field widths.
`default_nettype none

interface nmsdp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [nmsdp_pkg::CFG_IDX_W-1:0]    index;
  logic [nmsdp_pkg::CFG_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/nmsdp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nmsdp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/nmsdp_lane.sv]
// One multiply lane: gated int8 x int8 product, registered.
// Depends on nmsdp_pkg.
`default_nettype none

module nmsdp_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [nmsdp_pkg::LANE_W-1:0]  w,
  input  logic signed [nmsdp_pkg::LANE_W-1:0]  a,
  output logic signed [nmsdp_pkg::PROD_W-1:0]  prod
);

  // the cast keeps the multiply signed; a bare '0 arm would make it unsigned
  always_ff @(posedge clk) begin
    prod <= en ? nmsdp_pkg::PROD_W'(w * a) : '0;
  end

endmodule

`default_nettype wire

[rtl/core/nmsdp_merge.sv]
// Merge stage: sums lane products, then does the saturating accumulate
// and forms the row result. Depends on nmsdp_pkg.
`default_nettype none

module nmsdp_merge #(
  parameter int LANES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nmsdp_pkg::ctrl_t                     ctrl,
  input  logic signed [nmsdp_pkg::PROD_W-1:0]  prod [LANES],
  input  logic [nmsdp_pkg::CFG_W-1:0]          group_size,
  input  logic [nmsdp_pkg::CFG_W-1:0]          kept_per_group,
  output logic                                 push,
  output nmsdp_pkg::rsp_t                      res
);

  logic signed [nmsdp_pkg::SUM_W-1:0] tree_sum;
  logic signed [nmsdp_pkg::SUM_W-1:0] s3_sum;
  nmsdp_pkg::ctrl_t                   s3_ctrl;
  logic                               s3_valid;

  logic signed [nmsdp_pkg::ACC_W-1:0] acc;
  logic                               clip_seen;

  logic signed [nmsdp_pkg::ACC_W-1:0] base;
  logic signed [nmsdp_pkg::ACC_W:0]   total;
  logic signed [nmsdp_pkg::ACC_W-1:0] acc_next;
  logic                               clip_next;
  logic                               over_hi;
  logic                               over_lo;
  logic                               bad;

  always_comb begin
    tree_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      tree_sum = tree_sum + nmsdp_pkg::SUM_W'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_sum  <= tree_sum;
    s3_ctrl <= ctrl;
  end

  assign bad = (group_size < nmsdp_pkg::GS_MIN) ||
               (group_size > nmsdp_pkg::CFG_W'(LANES)) ||
               (kept_per_group >= group_size);

  always_comb begin
    base    = s3_ctrl.row_first ? s3_ctrl.bias : acc;
    total   = (nmsdp_pkg::ACC_W + 1)'(base) + (nmsdp_pkg::ACC_W + 1)'(s3_sum);
    // top two bits disagree: result left the int32 range
    over_hi = !total[nmsdp_pkg::ACC_W] && total[nmsdp_pkg::ACC_W-1];
    over_lo = total[nmsdp_pkg::ACC_W] && !total[nmsdp_pkg::ACC_W-1];
    if (over_hi) begin
      acc_next = nmsdp_pkg::ACC_MAX;
    end else if (over_lo) begin
      acc_next = nmsdp_pkg::ACC_MIN;
    end else begin
      acc_next = total[nmsdp_pkg::ACC_W-1:0];
    end
    clip_next = (s3_ctrl.row_first ? 1'b0 : clip_seen) | over_hi | over_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      clip_seen <= 1'b0;
    end else if (s3_valid && !bad) begin
      acc       <= acc_next;
      clip_seen <= clip_next;
    end
  end

  assign push = s3_valid && s3_ctrl.row_last;

  always_comb begin
    if (bad) begin
      res.y         = '0;
      res.status    = nmsdp_pkg::STATUS_ERR;
      res.saturated = 1'b0;
    end else begin
      res.y         = acc_next;
      res.status    = nmsdp_pkg::STATUS_OK;
      res.saturated = clip_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/nmsdp_rsp_fifo.sv]
// Small result queue between the merge stage and the result channel.
// Depends on nmsdp_pkg.
`default_nettype none

module nmsdp_rsp_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nmsdp_pkg::rsp_t  push_data,
  input  logic             out_ready,
  output logic             out_valid,
  output nmsdp_pkg::rsp_t  out_data
);

  nmsdp_pkg::rsp_t                   mem [nmsdp_pkg::FIFO_DEPTH];
  logic [nmsdp_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [nmsdp_pkg::FIFO_AW-1:0]     rd_ptr;
  logic [nmsdp_pkg::FIFO_CNT_W-1:0]  count;
  logic                              pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/nm_sparse_masked_dot_product.sv]
// N:M structured-sparse dot product, one row result per last weight group.
// Throughput: one beat (load or weight) per cycle while req.ready is high; the only
// feedback is the accumulator add. The last weight beat reads the store at the edge
// that accepts it, then passes lane multiply, sum and accumulate into the result queue.
// Up to 8 row results may be outstanding; beyond that req.ready drops.
// Reset clears pipeline, queue and accumulator, sets config defaults; store undefined.
`default_nettype none

module nm_sparse_masked_dot_product #(
  parameter int MAX_GROUPS     = 256,
  parameter int MAX_GROUP_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst,
  nmsdp_req_if.sink   req,
  nmsdp_rsp_if.source rsp,
  nmsdp_cfg_if.sink   cfg
);

  localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int LW = nmsdp_pkg::LANE_W;

  logic [nmsdp_pkg::CFG_W-1:0] group_size;
  logic [nmsdp_pkg::CFG_W-1:0] kept_per_group;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size     <= nmsdp_pkg::GS_RESET;
      kept_per_group <= nmsdp_pkg::KEPT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        nmsdp_pkg::REG_GROUP_SIZE: begin
          group_size <= cfg.data;
        end
        nmsdp_pkg::REG_KEPT_PER_GROUP: begin
          kept_per_group <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  // credit for results in flight or queued
  logic [nmsdp_pkg::FIFO_CNT_W-1:0] pending;
  logic                             req_fire;
  logic                             load_fire;
  logic                             weight_fire;
  logic                             rsp_fire;
  logic                             res_inc;

  assign req.ready   = (pending < nmsdp_pkg::FIFO_FULL);
  assign req_fire    = req.valid && req.ready;
  assign load_fire   = req_fire && (req.req_type == nmsdp_pkg::REQ_LOAD);
  assign weight_fire = req_fire && (req.req_type == nmsdp_pkg::REQ_WEIGHT);
  assign res_inc     = weight_fire && req.row_last;
  assign rsp_fire    = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (res_inc && !rsp_fire) begin
      pending <= pending + 1'b1;
    end else if (rsp_fire && !res_inc) begin
      pending <= pending - 1'b1;
    end
  end

  // group index to store slot, wrapping at MAX_GROUPS
  logic [AW-1:0] slot;

  generate
    if (MAX_GROUPS >= (1 << nmsdp_pkg::IDX_W)) begin : g_slot_direct
      assign slot = AW'(req.group_index);
    end else begin : g_slot_wrap
      logic [AW-1:0] slot_tab [1 << nmsdp_pkg::IDX_W];
      for (genvar i = 0; i < (1 << nmsdp_pkg::IDX_W); i++) begin : g_tab
        assign slot_tab[i] = AW'(i % MAX_GROUPS);
      end
      assign slot = slot_tab[req.group_index];
    end
  endgenerate

  logic [nmsdp_pkg::VALS_W-1:0] act;

  nmsdp_ram #(
    .WIDTH (nmsdp_pkg::VALS_W),
    .DEPTH (MAX_GROUPS)
  ) u_store (
    .clk   (clk),
    .we    (load_fire),
    .waddr (slot),
    .wdata (req.lane_values),
    .re    (weight_fire),
    .raddr (slot),
    .rdata (act)
  );

  // stage 1: weight beat fields, store data lands alongside
  logic                               s1_valid;
  logic [nmsdp_pkg::VALS_W-1:0]       s1_lanes;
  logic [LW-1:0]                      s1_mask;
  logic signed [nmsdp_pkg::ACC_W-1:0] s1_bias;
  logic                               s1_first;
  logic                               s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= weight_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (weight_fire) begin
      s1_lanes <= req.lane_values;
      s1_mask  <= req.mask;
      s1_bias  <= req.bias;
      s1_first <= req.row_first;
      s1_last  <= req.row_last;
    end
  end

  // stage 2: lane products
  logic signed [nmsdp_pkg::PROD_W-1:0] prod [MAX_GROUP_SIZE];

  generate
    for (genvar k = 0; k < MAX_GROUP_SIZE; k++) begin : g_lane
      nmsdp_lane u_lane (
        .clk  (clk),
        .en   (s1_mask[k] && (group_size > nmsdp_pkg::CFG_W'(k))),
        .w    (s1_lanes[k*LW +: LW]),
        .a    (act[k*LW +: LW]),
        .prod (prod[k])
      );
    end
  endgenerate

  logic                               s2_valid;
  logic signed [nmsdp_pkg::ACC_W-1:0] s2_bias;
  logic                               s2_first;
  logic                               s2_last;
  nmsdp_pkg::ctrl_t                   s2_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_bias  <= s1_bias;
    s2_first <= s1_first;
    s2_last  <= s1_last;
  end

  assign s2_ctrl.valid     = s2_valid;
  assign s2_ctrl.row_first = s2_first;
  assign s2_ctrl.row_last  = s2_last;
  assign s2_ctrl.bias      = s2_bias;

  // stages 3 and 4: sum and accumulate
  logic            push;
  nmsdp_pkg::rsp_t res;
  nmsdp_pkg::rsp_t head;
  logic            head_valid;

  nmsdp_merge #(
    .LANES (MAX_GROUP_SIZE)
  ) u_merge (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (s2_ctrl),
    .prod           (prod),
    .group_size     (group_size),
    .kept_per_group (kept_per_group),
    .push           (push),
    .res            (res)
  );

  nmsdp_rsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .out_ready (rsp.ready),
    .out_valid (head_valid),
    .out_data  (head)
  );

  assign rsp.valid     = head_valid;
  assign rsp.y         = head.y;
  assign rsp.status    = head.status;
  assign rsp.saturated = head.saturated;

endmodule

`default_nettype wire
